### src/biou_pkg.sv
// biou_pkg: shared types for the box IoU pipeline.
// No dependencies; imported by biou_axis and box_intersection_over_union.
package biou_pkg;

  // Load enables for the three registers of one axis overlap slice.
  typedef struct packed {
    logic prep;   // doubled centres, extent sum, extent limit
    logic diff;   // centre difference
    logic clip;   // overlap, clamped to the smaller extent
  } axis_en_t;

endpackage

### src/biou_if.sv
// biou_box_if / biou_iou_if: valid-ready channels for box pair requests and IoU results.
// No dependencies.
interface biou_box_if #(parameter int CW = 16) ();
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] left_a;
  logic signed [CW-1:0] top_a;
  logic signed [CW-1:0] height_a;
  logic signed [CW-1:0] width_a;
  logic signed [CW-1:0] left_b;
  logic signed [CW-1:0] top_b;
  logic signed [CW-1:0] height_b;
  logic signed [CW-1:0] width_b;

  modport source (
    output valid, left_a, top_a, height_a, width_a, left_b, top_b, height_b, width_b,
    input  ready
  );
  modport sink (
    input  valid, left_a, top_a, height_a, width_a, left_b, top_b, height_b, width_b,
    output ready
  );
endinterface

interface biou_iou_if #(parameter int FW = 16) ();
  logic        valid;
  logic        ready;
  logic [FW:0] overlap_fraction;
  logic        no_overlap;

  modport source (output valid, overlap_fraction, no_overlap, input ready);
  modport sink   (input valid, overlap_fraction, no_overlap, output ready);
endinterface

### src/biou_axis.sv
// biou_axis: three-register overlap slice for one axis, in half-units.
// Depends on biou_pkg (axis_en_t).
module biou_axis #(
  parameter int CW = 16
) (
  input  logic                 clk_i,
  input  biou_pkg::axis_en_t   en_i,
  input  logic signed [CW-1:0] org_a_i,
  input  logic signed [CW-1:0] ext_a_i,
  input  logic signed [CW-1:0] org_b_i,
  input  logic signed [CW-1:0] ext_b_i,
  output logic signed [CW+3:0] ovl_o
);
  import biou_pkg::*;

  localparam int DW = CW + 4;

  logic signed [DW-1:0] oa, ea, ob, eb;
  logic signed [DW-1:0] pa_d, pa_q, pb_d, pb_q, esum_d, esum_q, lim_d, lim_q;
  logic signed [DW-1:0] dif_d, dif_q, esum2_q, lim2_q;
  logic signed [DW-1:0] ovr, ovl_d, ovl_q;

  assign oa = DW'(org_a_i);
  assign ea = DW'(ext_a_i);
  assign ob = DW'(org_b_i);
  assign eb = DW'(ext_b_i);

  // twice the centre of each box, and the clamp limit 2*min(ext)
  assign pa_d   = (oa <<< 1) + ea;
  assign pb_d   = (ob <<< 1) + eb;
  assign esum_d = ea + eb;
  assign lim_d  = ((ea < eb) ? ea : eb) <<< 1;

  assign dif_d = pa_q - pb_q;

  // esum - |d|, folded into one add or subtract
  assign ovr   = dif_q[DW-1] ? (esum2_q + dif_q) : (esum2_q - dif_q);
  assign ovl_d = (ovr > lim2_q) ? lim2_q : ovr;

  always_ff @(posedge clk_i) begin
    if (en_i.prep) begin
      pa_q   <= pa_d;
      pb_q   <= pb_d;
      esum_q <= esum_d;
      lim_q  <= lim_d;
    end
    if (en_i.diff) begin
      dif_q   <= dif_d;
      esum2_q <= esum_q;
      lim2_q  <= lim_q;
    end
    if (en_i.clip) begin
      ovl_q <= ovl_d;
    end
  end

  assign ovl_o = ovl_q;

endmodule

### src/biou_div_cell.sv
// biou_div_cell: one restoring division step; a row of these forms the divider.
// No dependencies.
module biou_div_cell #(
  parameter int UW = 33,
  parameter int QW = 17
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [UW:0]   r_i,
  input  logic [QW-1:0] q_i,
  input  logic [UW-1:0] uni_i,
  input  logic          kill_i,
  output logic [UW:0]   r_o,
  output logic [QW-1:0] q_o,
  output logic [UW-1:0] uni_o,
  output logic          kill_o
);
  logic          qbit;
  logic [UW-1:0] rem;
  logic [UW:0]   r_d, r_q;
  logic [QW-1:0] q_d, q_q;
  logic [UW-1:0] uni_q;
  logic          kill_q;

  assign qbit = (r_i >= {1'b0, uni_i});
  assign rem  = UW'(r_i - (qbit ? {1'b0, uni_i} : '0));
  // remainder is below the divisor, so the shift cannot overflow
  assign r_d  = {rem, 1'b0};
  assign q_d  = {q_i[QW-2:0], qbit};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q    <= r_d;
      q_q    <= q_d;
      uni_q  <= uni_i;
      kill_q <= kill_i;
    end
  end

  assign r_o    = r_q;
  assign q_o    = q_q;
  assign uni_o  = uni_q;
  assign kill_o = kill_q;

endmodule

### src/box_intersection_over_union.sv
// box_intersection_over_union: pipelined IoU of two axis-aligned boxes.
// Depends on biou_pkg, biou_if (both interfaces), biou_axis and biou_div_cell.
//
//   channel  | dir | handshake            | payload
//   ---------+-----+----------------------+------------------------------------------
//   box_i    | in  | valid / ready        | left, top, height, width of boxes A and B
//   iou_o    | out | valid / ready        | overlap_fraction (FRACTION_BITS+1), no_overlap
//
// One box pair request per cycle while iou_o does not stall; the pipeline holds the
// three axis stages, the multiply, the union subtract, FRACTION_BITS+1 divider cells and the
// rounding register, all in one valid-tracked pipeline.
// Reset clears only the stage valid bits; data registers are left as they are.
// A stage loads whenever it, or any stage after it, is empty, so bubbles close up while
// a result waits; box_i.ready falls only once every stage holds a request and iou_o stalls.
module box_intersection_over_union #(
  parameter int COORD_BITS    = 16,
  parameter int FRACTION_BITS = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  biou_box_if.sink   box_i,
  biou_iou_if.source iou_o
);
  import biou_pkg::*;

  localparam int CW    = COORD_BITS;
  localparam int FW    = FRACTION_BITS;
  localparam int EW    = CW - 1;        // magnitude of a non-negative size
  localparam int AW    = 2 * EW;        // one box area
  localparam int SW    = AW + 1;        // sum of both areas
  localparam int IW    = 2 * CW;        // intersection, quarter-units
  localparam int UW    = 2 * CW + 1;    // union, quarter-units
  localparam int QW    = FW + 1;        // quotient
  localparam int DW    = CW + 4;        // signed half-unit axis values
  localparam int NCELL = FW + 1;        // integer bit plus FW fraction bits

  // stage numbering
  localparam int ST_MUL  = 3;
  localparam int ST_UNI  = 4;
  localparam int ST_CELL = 5;
  localparam int ST_OUT  = ST_CELL + NCELL;
  localparam int NS      = ST_OUT + 1;

  localparam logic [QW-1:0] ONE = QW'(1) << FW;

  // ---------------------------------------------------------------------------
  // Pipeline control: one valid bit per stage, ready from the stages after it.
  // ---------------------------------------------------------------------------
  logic [NS-1:0] valid_q, valid_d;
  logic [NS-1:0] vin;
  logic [NS-1:0] rdy;
  logic [NS-1:0] en;

  assign vin = {valid_q[NS-2:0], box_i.valid};

  for (genvar k = 0; k < NS; k++) begin : g_rdy
    // a hole anywhere downstream lets this stage move
    assign rdy[k] = iou_o.ready || !(&valid_q[NS-1:k]);
  end

  assign en      = rdy[NS-1:0] & vin;
  assign valid_d = (valid_q & ~rdy[NS-1:0]) | (vin & rdy[NS-1:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign box_i.ready = rdy[0];
  assign iou_o.valid = valid_q[NS-1];

  // ---------------------------------------------------------------------------
  // Stages 0..2: per-axis overlap slices, areas alongside
  // ---------------------------------------------------------------------------
  axis_en_t             axis_en;
  logic signed [DW-1:0] ovl_x, ovl_y;

  assign axis_en = '{prep: en[0], diff: en[1], clip: en[2]};

  biou_axis #(.CW(CW)) u_axis_y (
    .clk_i   (clk_i),
    .en_i    (axis_en),
    .org_a_i (box_i.top_a),
    .ext_a_i (box_i.height_a),
    .org_b_i (box_i.top_b),
    .ext_b_i (box_i.height_b),
    .ovl_o   (ovl_y)
  );

  biou_axis #(.CW(CW)) u_axis_x (
    .clk_i   (clk_i),
    .en_i    (axis_en),
    .org_a_i (box_i.left_a),
    .ext_a_i (box_i.width_a),
    .org_b_i (box_i.left_b),
    .ext_b_i (box_i.width_b),
    .ovl_o   (ovl_x)
  );

  // any negative size kills the request; sign bits are then dropped for the areas
  logic          neg_size;
  logic [AW-1:0] aa0_q, ab0_q;
  logic          kill0_q, kill1_q, kill2_q, kill3_q, kill4_q;
  logic [SW-1:0] asum1_q, asum2_q, asum3_q;

  assign neg_size = box_i.height_a[CW-1] | box_i.width_a[CW-1] |
                    box_i.height_b[CW-1] | box_i.width_b[CW-1];

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      aa0_q   <= AW'(box_i.height_a[EW-1:0]) * AW'(box_i.width_a[EW-1:0]);
      ab0_q   <= AW'(box_i.height_b[EW-1:0]) * AW'(box_i.width_b[EW-1:0]);
      kill0_q <= neg_size;
    end
    if (en[1]) begin
      asum1_q <= SW'(aa0_q) + SW'(ab0_q);
      kill1_q <= kill0_q;
    end
    if (en[2]) begin
      asum2_q <= asum1_q;
      kill2_q <= kill1_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: intersection product and the no-overlap test
  // Stage 4: union = 4*(areaA + areaB) - intersection
  // ---------------------------------------------------------------------------
  logic [IW-1:0] inter3_q, inter4_q;
  logic [UW-1:0] uni_d, uni4_q;

  // clamped overlap is at most 2^CW - 2 when positive, so the low bits carry it
  always_ff @(posedge clk_i) begin
    if (en[ST_MUL]) begin
      inter3_q <= IW'(ovl_x[CW-1:0]) * IW'(ovl_y[CW-1:0]);
      asum3_q  <= asum2_q;
      kill3_q  <= kill2_q | (ovl_x <= 0) | (ovl_y <= 0);
    end
  end

  assign uni_d = {asum3_q, 2'b00} - UW'(inter3_q);

  always_ff @(posedge clk_i) begin
    if (en[ST_UNI]) begin
      uni4_q   <= uni_d;
      inter4_q <= inter3_q;
      kill4_q  <= kill3_q | (uni_d == '0);
    end
  end

  // ---------------------------------------------------------------------------
  // Divider: a row of restoring cells, one quotient bit each, integer bit first.
  // The last cell hands on twice the final remainder, which feeds the rounding test.
  // ---------------------------------------------------------------------------
  logic [UW:0]   r_c    [NCELL+1];
  logic [QW-1:0] q_c    [NCELL+1];
  logic [UW-1:0] uni_c  [NCELL+1];
  logic          kill_c [NCELL+1];

  assign r_c[0]    = (UW+1)'(inter4_q);
  assign q_c[0]    = '0;
  assign uni_c[0]  = uni4_q;
  assign kill_c[0] = kill4_q;

  for (genvar j = 0; j < NCELL; j++) begin : g_cell
    biou_div_cell #(.UW(UW), .QW(QW)) u_cell (
      .clk_i  (clk_i),
      .en_i   (en[ST_CELL+j]),
      .r_i    (r_c[j]),
      .q_i    (q_c[j]),
      .uni_i  (uni_c[j]),
      .kill_i (kill_c[j]),
      .r_o    (r_c[j+1]),
      .q_o    (q_c[j+1]),
      .uni_o  (uni_c[j+1]),
      .kill_o (kill_c[j+1])
    );
  end

  // ---------------------------------------------------------------------------
  // Output register: round to nearest (ties up), clamp to one, zero on kill
  // ---------------------------------------------------------------------------
  logic          rnd;
  logic [QW:0]   q_rnd;
  logic [QW-1:0] frac_d, frac_q;
  logic          no_ovl_q;

  assign rnd   = (r_c[NCELL] >= (UW+1)'(uni_c[NCELL]));
  assign q_rnd = (QW+1)'(q_c[NCELL]) + (QW+1)'(rnd);

  always_comb begin
    if (kill_c[NCELL]) begin
      frac_d = '0;
    end else if (q_rnd > (QW+1)'(ONE)) begin
      frac_d = ONE;
    end else begin
      frac_d = q_rnd[QW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[ST_OUT]) begin
      frac_q   <= frac_d;
      no_ovl_q <= kill_c[NCELL];
    end
  end

  assign iou_o.overlap_fraction = frac_q;
  assign iou_o.no_overlap       = no_ovl_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_neg_kills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (box_i.valid && box_i.ready && neg_size) |=> (valid_q[0] && kill0_q))
    else $error("negative size request not marked as killed");

  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !box_i.ready |-> ((&valid_q) && !iou_o.ready))
    else $error("input stalled while the pipeline has room");

  a_result_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    iou_o.valid |-> ((iou_o.overlap_fraction <= ONE) &&
                     (!iou_o.no_overlap || (iou_o.overlap_fraction == '0))))
    else $error("result fraction out of range or non-zero with no overlap");

endmodule
